[rtl/core/mpws_pkg.sv]
// Shared types, constants and helpers for the multi-pump watering sequencer.
package mpws_pkg;

    localparam int NUM_PUMPS_DEF = 3;
    localparam int CNT_W         = 18;
    localparam int SENSOR_PUMPS  = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [6:0]       WET_THRESHOLD_RST = 7'd75;

    // Opcodes of an input word
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Kinds of a result word
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_POWER  = 1'b1;

    // Request status codes
    localparam logic [2:0] ST_NO_PUMP = 3'd0;
    localparam logic [2:0] ST_BUSY    = 3'd1;
    localparam logic [2:0] ST_ABSENT  = 3'd2;
    localparam logic [2:0] ST_WET     = 3'd3;
    localparam logic [2:0] ST_STARTED = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_WAIT = 2'd2
    } mode_t;

    typedef struct packed {
        logic              opcode;
        logic [7:0]        pump_number;
        logic [7:0]        pause_seconds;
        logic [7:0]        water_seconds;
        logic signed [7:0] moisture_one;
        logic signed [7:0] moisture_two;
        logic signed [7:0] moisture_three;
    } in_word_t;

    typedef struct packed {
        logic       kind;
        logic [2:0] status;
        logic [1:0] cmd_pump;
        logic       power_on;
        logic       last;
    } out_word_t;

    // Shared compare unit results
    typedef struct packed {
        logic [CNT_W-1:0] cnt_inc;
        logic             reached;
        logic             absent;
        logic             dry;
    } alu_res_t;

    // Sequencer to output stage
    typedef struct packed {
        logic push;
        logic flush;
    } ob_ctrl_t;

    // Output stage to sequencer
    typedef struct packed {
        logic push_ready;
        logic flush_done;
    } ob_stat_t;

    // Seconds to milliseconds: s*1000 = s*1024 - s*16 - s*8
    function automatic logic [CNT_W-1:0] sec_to_ms(input logic [7:0] s);
        logic [CNT_W-1:0] se;
        se = CNT_W'(s);
        return (se << 10) - (se << 4) - (se << 3);
    endfunction

    function automatic out_word_t mk_status(input logic [2:0] st);
        out_word_t w;
        w.kind     = KIND_STATUS;
        w.status   = st;
        w.cmd_pump = 2'd0;
        w.power_on = 1'b0;
        w.last     = 1'b0;
        return w;
    endfunction

    function automatic out_word_t mk_power(input logic [1:0] pump, input logic on);
        out_word_t w;
        w.kind     = KIND_POWER;
        w.status   = ST_NO_PUMP;
        w.cmd_pump = pump;
        w.power_on = on;
        w.last     = 1'b0;
        return w;
    endfunction

endpackage

[rtl/core/mpws_alu.sv]
// Shared counter and sensor compare unit, used once per sequencer step.
module mpws_alu
    import mpws_pkg::*;
(
    input  logic [CNT_W-1:0] cnt,
    input  logic [CNT_W-1:0] limit,
    input  logic signed [7:0] moisture,
    input  logic [6:0]       threshold,
    output alu_res_t         res
);

    always_comb
    begin
        // saturate at the counter ceiling
        res.cnt_inc = (cnt == CNT_MAX) ? cnt : cnt + CNT_W'(1);
        res.reached = (res.cnt_inc >= limit);
        res.absent  = moisture[7];
        res.dry     = !moisture[7] && (moisture[6:0] < threshold);
    end

endmodule

[rtl/core/mpws_out_stage.sv]
// Output stage: one pending word plus an output register, marks the last word.
module mpws_out_stage
    import mpws_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ob_ctrl_t  ctrl,
    input  out_word_t push_word,
    output ob_stat_t  stat,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    logic      pend_valid_reg, pend_valid_next;
    out_word_t pend_reg, pend_next;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_reg, out_next;
    logic      out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        stat.push_ready = !pend_valid_reg || out_free;
        stat.flush_done = !pend_valid_reg || out_free;

        if (ctrl.push && stat.push_ready)
        begin
            // advance the held word, hold the new one until we know what follows
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_next.last  = 1'b0;
                out_valid_next = 1'b1;
            end
            pend_next       = push_word;
            pend_valid_next = 1'b1;
        end
        else if (ctrl.flush && pend_valid_reg && out_free)
        begin
            out_next        = pend_reg;
            out_next.last   = 1'b1;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

[rtl/core/multi_pump_watering_sequencer_core.sv]
// Top level of the multi-pump watering sequencer: sequencer, pump state and wiring.
//
// The block takes one input word at a time and is not ready again until every
// result word of it has been handed to the output stage. A start request runs
// through S_IDLE to accept it, S_REQ to check the pump, S_EMIT to emit the status
// (preceded by an on command when watering starts) and S_FLUSH to mark the final
// word. A millisecond tick visits the pumps one after another in S_VISIT through
// a single shared compare unit, one pump a cycle while no power command is being
// emitted; each power command is emitted in S_EMIT and the sequence is closed in
// S_FLUSH. A stalled output holds S_EMIT and S_FLUSH. The final result word of an
// input has last set; a tick that changes nothing returns no words. Moisture
// sensors exist for pumps 1 to 3 only; higher pumps read as sensor absent. The
// wet threshold is written through cfg_we and cfg_data; the user must write it
// only while the block is idle, the block itself does not enforce it.
module multi_pump_watering_sequencer_core
    import mpws_pkg::*;
#(
    parameter int NUM_PUMPS = NUM_PUMPS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_data,
    input  logic       cfg_we,
    input  logic [6:0] cfg_data
);

    localparam int IDX_W = (NUM_PUMPS > 1) ? $clog2(NUM_PUMPS) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_REQ   = 5'b00010,
        S_VISIT = 5'b00100,
        S_EMIT  = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    // Sequencer registers
    state_t     state_reg, state_next;
    in_word_t   inw_reg, inw_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    out_word_t  em_a_reg, em_a_next;
    out_word_t  em_b_reg, em_b_next;
    logic [1:0] em_cnt_reg, em_cnt_next;
    logic       tail_reg, tail_next;
    logic [6:0] thr_reg;

    // Per-pump state
    mode_t            mode_reg    [NUM_PUMPS];
    logic [CNT_W-1:0] elapsed_reg [NUM_PUMPS];
    logic [CNT_W-1:0] run_reg     [NUM_PUMPS];
    logic [CNT_W-1:0] pause_reg   [NUM_PUMPS];

    // Pump state write port, one pump per cycle
    logic             wr_mode_en, wr_elapsed_en, wr_run_en, wr_pause_en;
    mode_t            wr_mode;
    logic [CNT_W-1:0] wr_elapsed, wr_run, wr_pause;

    logic [7:0]        idx_ext;
    logic              is_last_pump;
    logic [1:0]        cur_pump;
    logic              num_ok;
    mode_t             cur_mode;
    logic [CNT_W-1:0]  cur_limit;
    logic signed [7:0] cur_moist;
    alu_res_t          alu;
    ob_ctrl_t          ob_ctrl;
    ob_stat_t          ob_stat;

    assign idx_ext      = 8'(idx_reg);
    assign is_last_pump = (idx_ext == 8'(NUM_PUMPS - 1));
    assign cur_pump     = 2'(idx_ext + 8'd1);
    assign num_ok       = (inw_reg.pump_number >= 8'd1)
                       && (inw_reg.pump_number <= 8'(NUM_PUMPS));
    assign cur_mode     = mode_reg[idx_reg];
    assign cur_limit    = (cur_mode == MODE_RUN) ? run_reg[idx_reg] : pause_reg[idx_reg];

    // Pick the sensor of the pump in hand; no sensor beyond the third pump
    always_comb
    begin
        case (idx_ext)
            8'd0:    cur_moist = inw_reg.moisture_one;
            8'd1:    cur_moist = inw_reg.moisture_two;
            8'd2:    cur_moist = inw_reg.moisture_three;
            default: cur_moist = -8'sd1;
        endcase
    end

    mpws_alu u_alu (
        .cnt       (elapsed_reg[idx_reg]),
        .limit     (cur_limit),
        .moisture  (cur_moist),
        .threshold (thr_reg),
        .res       (alu)
    );

    mpws_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ob_ctrl),
        .push_word (em_a_reg),
        .stat      (ob_stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        inw_next      = inw_reg;
        idx_next      = idx_reg;
        em_a_next     = em_a_reg;
        em_b_next     = em_b_reg;
        em_cnt_next   = em_cnt_reg;
        tail_next     = tail_reg;
        in_ready      = 1'b0;
        ob_ctrl.push  = 1'b0;
        ob_ctrl.flush = 1'b0;
        wr_mode_en    = 1'b0;
        wr_elapsed_en = 1'b0;
        wr_run_en     = 1'b0;
        wr_pause_en   = 1'b0;
        wr_mode       = MODE_IDLE;
        wr_elapsed    = '0;
        wr_run        = '0;
        wr_pause      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    inw_next = in_data;
                    if (in_data.opcode == OP_START)
                    begin
                        idx_next   = IDX_W'(in_data.pump_number - 8'd1);
                        state_next = S_REQ;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_VISIT;
                    end
                end
            end

            S_REQ:
            begin
                em_cnt_next = 2'd1;
                tail_next   = 1'b1;
                state_next  = S_EMIT;
                if (!num_ok)
                    em_a_next = mk_status(ST_NO_PUMP);
                else if (cur_mode == MODE_RUN || cur_mode == MODE_WAIT)
                    em_a_next = mk_status(ST_BUSY);
                else if (alu.absent)
                    em_a_next = mk_status(ST_ABSENT);
                else if (!alu.dry)
                    em_a_next = mk_status(ST_WET);
                else
                begin
                    // switch on, then report started
                    em_a_next     = mk_power(inw_reg.pump_number[1:0], 1'b1);
                    em_b_next     = mk_status(ST_STARTED);
                    em_cnt_next   = 2'd2;
                    wr_mode_en    = 1'b1;
                    wr_mode       = MODE_RUN;
                    wr_elapsed_en = 1'b1;
                    wr_elapsed    = '0;
                    wr_run_en     = 1'b1;
                    wr_run        = sec_to_ms(inw_reg.water_seconds);
                    wr_pause_en   = 1'b1;
                    wr_pause      = sec_to_ms(inw_reg.pause_seconds);
                end
            end

            S_VISIT:
            begin
                em_cnt_next = 2'd0;
                tail_next   = is_last_pump;
                case (cur_mode)
                    MODE_RUN:
                    begin
                        wr_elapsed_en = 1'b1;
                        if (alu.reached)
                        begin
                            em_a_next   = mk_power(cur_pump, 1'b0);
                            em_b_next   = mk_power(cur_pump, 1'b0);
                            em_cnt_next = 2'd2;
                            wr_mode_en  = 1'b1;
                            wr_mode     = MODE_WAIT;
                            wr_elapsed  = '0;
                        end
                        else
                            wr_elapsed = alu.cnt_inc;
                    end
                    MODE_WAIT:
                    begin
                        wr_elapsed_en = 1'b1;
                        wr_mode_en    = alu.reached;
                        if (!alu.reached)
                            wr_elapsed = alu.cnt_inc;
                        else if (alu.dry)
                        begin
                            em_a_next   = mk_power(cur_pump, 1'b1);
                            em_cnt_next = 2'd1;
                            wr_mode     = MODE_RUN;
                        end
                        else
                        begin
                            wr_mode   = MODE_IDLE;
                            wr_run_en = 1'b1;
                        end
                    end
                    default:
                    begin
                        // idle pumps are skipped
                    end
                endcase

                if (!is_last_pump)
                    idx_next = idx_reg + IDX_W'(1);

                if (em_cnt_next != 2'd0)
                    state_next = S_EMIT;
                else if (is_last_pump)
                    state_next = S_FLUSH;
            end

            S_EMIT:
            begin
                ob_ctrl.push = 1'b1;
                if (ob_stat.push_ready)
                begin
                    em_a_next   = em_b_reg;
                    em_cnt_next = em_cnt_reg - 2'd1;
                    if (em_cnt_reg == 2'd1)
                        state_next = tail_reg ? S_FLUSH : S_VISIT;
                end
            end

            S_FLUSH:
            begin
                // release the held word with last set
                ob_ctrl.flush = 1'b1;
                if (ob_stat.flush_done)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            em_cnt_reg <= 2'd0;
            tail_reg   <= 1'b0;
            idx_reg    <= '0;
            thr_reg    <= WET_THRESHOLD_RST;
        end
        else
        begin
            state_reg  <= state_next;
            em_cnt_reg <= em_cnt_next;
            tail_reg   <= tail_next;
            idx_reg    <= idx_next;
            if (cfg_we)
                thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        inw_reg  <= inw_next;
        em_a_reg <= em_a_next;
        em_b_reg <= em_b_next;
    end

    // Pump state: idle with zeroed counters out of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PUMPS; i++)
            begin
                mode_reg[i]    <= MODE_IDLE;
                elapsed_reg[i] <= '0;
                run_reg[i]     <= '0;
                pause_reg[i]   <= '0;
            end
        end
        else
        begin
            if (wr_mode_en)
                mode_reg[idx_reg] <= wr_mode;
            if (wr_elapsed_en)
                elapsed_reg[idx_reg] <= wr_elapsed;
            if (wr_run_en)
                run_reg[idx_reg] <= wr_run;
            if (wr_pause_en)
                pause_reg[idx_reg] <= wr_pause;
        end
    end

endmodule

[tb/sv/mpws_checker.sv]
// Checker for the watering sequencer: predicts result words and compares them.
module mpws_checker
    import mpws_pkg::*;
#(
    parameter int NUM_PUMPS = NUM_PUMPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_word_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_word_t   out_data,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data,
    output int unsigned fail_count,
    output int unsigned words_due
);

    localparam logic [CNT_W-1:0] MS_PER_SECOND = CNT_W'(1000);

    mode_t            pump_state [NUM_PUMPS];
    logic [CNT_W-1:0] ms_count   [NUM_PUMPS];
    logic [CNT_W-1:0] burst_ms   [NUM_PUMPS];
    logic [CNT_W-1:0] rest_ms    [NUM_PUMPS];
    logic [6:0]       threshold;
    out_word_t        planned_words [$];

    // Only pumps 1 to 3 have a sensor; the rest read as absent
    function automatic int sensor_reading(input in_word_t w, input int idx);
        case (idx)
            0:       return int'($signed(w.moisture_one));
            1:       return int'($signed(w.moisture_two));
            2:       return int'($signed(w.moisture_three));
            default: return -1;
        endcase
    endfunction

    task automatic queue_word(input logic k, input logic [2:0] st, input logic [1:0] pump,
                              input logic on);
        out_word_t w;
        w.kind     = k;
        w.status   = st;
        w.cmd_pump = pump;
        w.power_on = on;
        w.last     = 1'b0;
        planned_words.push_back(w);
    endtask

    task automatic plan_pump_words(input in_word_t w);
        int         num;
        int         idx;
        int         p;
        int         size_at_entry;
        logic [2:0] st;
        out_word_t  tail;
        size_at_entry = planned_words.size();
        if (w.opcode == OP_START)
        begin
            num = int'(w.pump_number);
            if (num < 1 || num > NUM_PUMPS)
                st = ST_NO_PUMP;
            else
            begin
                idx = num - 1;
                p   = sensor_reading(w, idx);
                if (pump_state[idx] == MODE_RUN || pump_state[idx] == MODE_WAIT)
                    st = ST_BUSY;
                else if (p < 0)
                    st = ST_ABSENT;
                else if (p >= int'(threshold))
                    st = ST_WET;
                else
                begin
                    queue_word(KIND_POWER, ST_NO_PUMP, 2'(num), 1'b1);
                    pump_state[idx] = MODE_RUN;
                    ms_count[idx]   = '0;
                    rest_ms[idx]    = CNT_W'(w.pause_seconds) * MS_PER_SECOND;
                    burst_ms[idx]   = CNT_W'(w.water_seconds) * MS_PER_SECOND;
                    st = ST_STARTED;
                end
            end
            queue_word(KIND_STATUS, st, 2'd0, 1'b0);
        end
        else
        begin
            for (int i = 0; i < NUM_PUMPS; i++)
            begin
                if (pump_state[i] == MODE_RUN || pump_state[i] == MODE_WAIT)
                begin
                    if (ms_count[i] != CNT_MAX)
                        ms_count[i] = ms_count[i] + 1'b1;
                    if (pump_state[i] == MODE_RUN)
                    begin
                        if (ms_count[i] >= burst_ms[i])
                        begin
                            queue_word(KIND_POWER, ST_NO_PUMP, 2'(i + 1), 1'b0);
                            queue_word(KIND_POWER, ST_NO_PUMP, 2'(i + 1), 1'b0);
                            pump_state[i] = MODE_WAIT;
                            ms_count[i]   = '0;
                        end
                    end
                    else if (ms_count[i] >= rest_ms[i])
                    begin
                        p = sensor_reading(w, i);
                        if (p >= 0 && p < int'(threshold))
                        begin
                            queue_word(KIND_POWER, ST_NO_PUMP, 2'(i + 1), 1'b1);
                            pump_state[i] = MODE_RUN;
                        end
                        else
                        begin
                            pump_state[i] = MODE_IDLE;
                            burst_ms[i]   = '0;
                        end
                        ms_count[i] = '0;
                    end
                end
            end
        end
        // mark the final word of this input
        if (planned_words.size() > size_at_entry)
        begin
            tail      = planned_words.pop_back();
            tail.last = 1'b1;
            planned_words.push_back(tail);
        end
    endtask

    task automatic check_word(input out_word_t got);
        out_word_t want;
        if (planned_words.size() == 0)
        begin
            $error("result word %h arrived with nothing expected", got);
            fail_count++;
        end
        else
        begin
            want = planned_words.pop_front();
            if (got.kind != want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                fail_count++;
            end
            if (got.status != want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fail_count++;
            end
            if (got.cmd_pump != want.cmd_pump)
            begin
                $error("cmd_pump: expected %0d, got %0d", want.cmd_pump, got.cmd_pump);
                fail_count++;
            end
            if (got.power_on != want.power_on)
            begin
                $error("power_on: expected %0d, got %0d", want.power_on, got.power_on);
                fail_count++;
            end
            if (got.last != want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PUMPS; i++)
            begin
                pump_state[i] = MODE_IDLE;
                ms_count[i]   = '0;
                burst_ms[i]   = '0;
                rest_ms[i]    = '0;
            end
            threshold = WET_THRESHOLD_RST;
            planned_words.delete();
            fail_count = 0;
            words_due  = 0;
        end
        else
        begin
            if (cfg_we)
                threshold = cfg_data;
            if (in_valid && in_ready)
                plan_pump_words(in_data);
            if (out_valid && out_ready)
                check_word(out_data);
            words_due = planned_words.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for the watering sequencer: clock, reset, stimulus and verdict.
module tb_top;
    import mpws_pkg::*;

    // Tail after the last expected word: a tick that reports nothing may still be
    // walking the pumps, so allow a good margin.
    localparam int SETTLE_CYCLES = 24;
    // Long receiver hold-off, enough for the block to back up and drop in_ready
    localparam int PRESS_CYCLES  = 300;
    // Slowest correct run: some 250 words, each with six results that each wait
    // out a long stall, plus the sender's longest gap and the one long hold-off;
    // taken several times over.
    localparam int CYCLE_LIMIT   = 1000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_word_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_word_t   out_data;
    logic        cfg_we;
    logic [6:0]  cfg_data;

    int unsigned fail_count;
    int unsigned words_due;
    int unsigned cycle_count;

    // steady: the sender offers back to back; press_req: ask the receiver to hold off
    bit steady;
    bit press_req;

    multi_pump_watering_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    mpws_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .words_due  (words_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop should the block hang
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Mostly plausible readings, some absent sensors, some arbitrary bytes
    function automatic byte rand_moisture();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return byte'($urandom_range(0, 100));
        else if (r < 90)
            return -8'sd1;
        else
            return byte'($urandom);
    endfunction

    function automatic in_word_t tick_word(input byte m1, input byte m2, input byte m3);
        in_word_t w;
        w.opcode         = OP_TICK;
        w.pump_number    = 8'($urandom);
        w.pause_seconds  = 8'($urandom);
        w.water_seconds  = 8'($urandom);
        w.moisture_one   = m1;
        w.moisture_two   = m2;
        w.moisture_three = m3;
        return w;
    endfunction

    function automatic in_word_t start_word(input logic [7:0] pump, input logic [7:0] pause,
                                            input logic [7:0] water, input byte m1,
                                            input byte m2, input byte m3);
        in_word_t w;
        w.opcode         = OP_START;
        w.pump_number    = pump;
        w.pause_seconds  = pause;
        w.water_seconds  = water;
        w.moisture_one   = m1;
        w.moisture_two   = m2;
        w.moisture_three = m3;
        return w;
    endfunction

    // Lengths are mostly zero so pumps cycle every tick or two; a one-second
    // length parks the pump for a thousand ticks, so keep it rare.
    function automatic logic [7:0] rand_seconds();
        return ($urandom_range(0, 99) < 96) ? 8'd0 : 8'd1;
    endfunction

    function automatic in_word_t random_word();
        int         r;
        logic [7:0] pump;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                pump = 8'($urandom_range(1, 3));
            else if (r < 85)
                pump = 8'd0;
            else
                pump = 8'($urandom_range(4, 255));
            return start_word(pump, rand_seconds(), rand_seconds(),
                              rand_moisture(), rand_moisture(), rand_moisture());
        end
        return tick_word(rand_moisture(), rand_moisture(), rand_moisture());
    endfunction

    // Offer one word and hold it until the block takes it. Valid stays high
    // into the next word when there is no gap, so it is never dropped and
    // raised in the same step.
    task automatic send_word(input in_word_t w);
        int gap;
        gap = steady ? 0 : idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_word(random_word());
    endtask

    // Drop valid, wait for every expected word, then let any silent tick finish
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [6:0] value);
        wait_quiet();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Receiver: random stretches of ready and of stall, plus one long hold-off
    // on request while the sender keeps offering.
    initial
    begin
        int run_len;
        int hold;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (press_req)
            begin
                press_req = 1'b0;
                out_ready <= 1'b0;
                repeat (PRESS_CYCLES) @(posedge clk);
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    run_len = $urandom_range(40, 150);
                else
                    run_len = $urandom_range(1, 12);
                out_ready <= 1'b1;
                repeat (run_len) @(posedge clk);
                hold = idle_length();
                if (hold > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (hold) @(posedge clk);
                end
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        cycle_count = 0;
        steady      = 1'b0;
        press_req   = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed words at the reset threshold
        send_word(tick_word(8'sd0, 8'sd0, 8'sd0));                         // nothing running
        send_word(start_word(8'd0, 8'd255, 8'd255, -8'sd128, 8'sd127, -8'sd1));
        send_word(start_word(8'd4, 8'd0, 8'd0, 8'sd10, 8'sd10, 8'sd10));
        send_word(start_word(8'd255, 8'd170, 8'd85, 8'sd10, 8'sd10, 8'sd10));
        send_word(start_word(8'd1, 8'd0, 8'd0, -8'sd1, 8'sd10, 8'sd10));   // sensor absent
        send_word(start_word(8'd2, 8'd0, 8'd0, 8'sd10, 8'sd75, 8'sd10));   // wet at threshold
        send_word(start_word(8'd3, 8'd0, 8'd0, 8'sd10, 8'sd10, 8'sd100));
        send_word(start_word(8'd1, 8'd0, 8'd0, 8'sd74, 8'sd10, 8'sd10));   // just dry: starts
        send_word(start_word(8'd1, 8'd0, 8'd0, 8'sd10, 8'sd10, 8'sd10));   // busy running
        send_word(start_word(8'd2, 8'd0, 8'd0, 8'sd10, 8'sd0, 8'sd10));
        send_word(start_word(8'd3, 8'd0, 8'd0, 8'sd10, 8'sd10, 8'sd74));
        send_word(tick_word(8'sd10, 8'sd10, 8'sd10));                      // six off commands
        send_word(start_word(8'd2, 8'd0, 8'd0, 8'sd10, 8'sd10, 8'sd10));   // busy waiting
        send_word(tick_word(8'sd10, -8'sd1, 8'sd75));                      // restart, idle, idle
        send_word(tick_word(8'sd100, 8'sd0, 8'sd0));
        send_word(tick_word(8'sd0, 8'sd0, 8'sd0));
        send_word(tick_word(8'sd0, 8'sd0, 8'sd0));
        send_word(tick_word(-8'sd128, 8'sd0, 8'sd0));                      // back to idle
        send_word(start_word(8'd3, 8'd0, 8'd0, 8'sd0, 8'sd0, -8'sd128));
        send_word(start_word(8'd3, 8'd0, 8'd0, 8'sd0, 8'sd0, 8'sd127));

        // Threshold at zero: no soil is dry
        write_threshold(7'd0);
        send_word(start_word(8'd1, 8'd0, 8'd0, 8'sd0, 8'sd0, 8'sd0));
        send_word(start_word(8'd2, 8'd0, 8'd0, 8'sd0, -8'sd1, 8'sd0));

        // Threshold above 100: even full readings count as dry
        write_threshold(7'd127);
        send_word(start_word(8'd1, 8'd0, 8'd0, 8'sd100, 8'sd0, 8'sd0));
        send_word(tick_word(8'sd100, 8'sd0, 8'sd0));
        send_word(tick_word(8'sd100, 8'sd0, 8'sd0));
        send_word(tick_word(8'sd100, 8'sd0, 8'sd0));
        send_word(tick_word(-8'sd1, 8'sd0, 8'sd0));

        // Random words under several thresholds; hold the receiver off early on
        write_threshold(7'($urandom_range(1, 99)));
        press_req = 1'b1;
        run_random(42);
        write_threshold(7'd100);
        steady = 1'b1;
        run_random(42);
        steady = 1'b0;
        write_threshold(7'd0);
        run_random(42);
        write_threshold(7'd127);
        run_random(42);
        write_threshold(7'($urandom_range(0, 127)));
        run_random(42);

        // Longest lengths: these pumps stay busy for the rest of the run
        write_threshold(7'd75);
        send_word(start_word(8'd3, 8'd255, 8'd255, 8'sd0, 8'sd0, 8'sd0));
        send_word(start_word(8'd1, 8'd255, 8'd0, 8'sd0, 8'sd0, 8'sd0));
        send_word(start_word(8'd2, 8'd0, 8'd255, 8'sd0, 8'sd0, 8'sd0));
        repeat (4) send_word(tick_word(8'sd0, 8'sd0, 8'sd0));
        send_word(start_word(8'd1, 8'd0, 8'd0, 8'sd0, 8'sd0, 8'sd0));
        send_word(start_word(8'd3, 8'd0, 8'd0, 8'sd0, 8'sd0, 8'sd0));

        wait_quiet();
        if (fail_count == 0 && words_due == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
